FILE: src/assert_macros.svh
// assertion macros used by bpra_engine
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, quiet during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/bpra_pkg.sv
// shared types and constants for the bitmap page run allocator
// depends on nothing
package bpra_pkg;
  localparam logic [31:0] BASE_RESET = 32'hC010_0000;
  localparam logic [12:0] PAGES_RESET = 13'd4096;
  localparam int PAGE_SHIFT = 12;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;
  localparam logic [0:0] REG_BASE = 1'b0;
  localparam logic [0:0] REG_PAGES = 1'b1;

  // request as held by the engine
  typedef struct packed {
    logic        req_type;
    logic [12:0] page_count;
    logic [31:0] page_address;
  } req_t;

  // result beat
  typedef struct packed {
    logic [31:0] result_address;
    logic        success;
  } rsp_t;
endpackage

FILE: src/bpra_if.sv
// valid/ready channel interfaces for requests and results
// depends on bpra_pkg
interface bpra_req_if import bpra_pkg::*; ();
  logic valid;
  logic ready;
  logic req_type;
  logic [12:0] page_count;
  logic [31:0] page_address;
  modport source (output valid, req_type, page_count, page_address, input ready);
  modport sink (input valid, req_type, page_count, page_address, output ready);
endinterface

interface bpra_rsp_if import bpra_pkg::*; ();
  logic valid;
  logic ready;
  logic [31:0] result_address;
  logic success;
  modport source (output valid, result_address, success, input ready);
  modport sink (input valid, result_address, success, output ready);
endinterface

FILE: src/bpra_bitmap_ram.sv
// bitmap word memory, one write and one registered read port
// depends on nothing
module bpra_bitmap_ram #(
  parameter int WORDS = 128,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [WORDS];

  // synchronous write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/bpra_engine.sv
// scan and mark/clear sequencer over the bitmap memory
// depends on bpra_pkg, bpra_bitmap_ram, assert_macros.svh
`include "assert_macros.svh"
module bpra_engine import bpra_pkg::*; #(
  parameter int POOL_PAGES_MAX = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic [31:0] base_r,
  input  logic [12:0] pages_r
);
  localparam int WORDS = (POOL_PAGES_MAX + 31) / 32;
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IW = $clog2(POOL_PAGES_MAX) + 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_MARK_RD, S_MARK_WR, S_RESP} state_t;

  state_t      state_r;
  logic        free_r;
  logic [12:0] cnt_r;
  logic [12:0] run_r;
  logic [IW-1:0] scan_r;   // page index of current scan bit
  logic [IW-1:0] limit_r;
  logic [19:0] pos_r;      // mark/clear current page
  logic [13:0] left_r;     // pages left to mark or clear
  logic        rd_ok_r;    // rdata valid for word at scan_r
  logic [AW-1:0] clr_r;
  logic [31:0] res_addr_r;
  logic        res_ok_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  bpra_bitmap_ram #(.WORDS(WORDS), .AW(AW)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [31:0] off;
  logic [19:0] first_idx;
  logic [IW-1:0] act;
  assign off = req.page_address - base_r;
  assign first_idx = off[31:12];
  assign act = ({4'd0, pages_r} > 17'(POOL_PAGES_MAX)) ? IW'(POOL_PAGES_MAX) : IW'(pages_r);

  // mark range mask for the word at pos_r
  logic [31:0] mmask;
  logic [5:0]  nbits;
  logic [4:0]  boff;
  assign boff = pos_r[4:0];
  always_comb begin
    logic [5:0] room;
    room = 6'd32 - {1'b0, boff};
    nbits = (left_r < 14'(room)) ? left_r[5:0] : room;
    mmask = ((nbits == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1)) << boff;
  end

  logic pos_in;
  assign pos_in = pos_r < 20'(POOL_PAGES_MAX);

  // scan bit from current word
  logic cur_bit;
  assign cur_bit = rdata[scan_r[4:0]];

  always_comb begin
    we = 1'b0;
    waddr = pos_r[AW+4:5];
    wdata = free_r ? (rdata & ~mmask) : (rdata | mmask);
    raddr = scan_r[AW+4:5];
    if (state_r == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_r;
      wdata = '0;
    end else if (state_r == S_MARK_RD) begin
      raddr = pos_r[AW+4:5];
    end else if (state_r == S_MARK_WR) begin
      we = pos_in;
      raddr = pos_r[AW+4:5];
    end else if (state_r == S_SCAN && rd_ok_r && !cur_bit && run_r + 13'd1 != cnt_r &&
                 scan_r[4:0] == 5'd31) begin
      raddr = AW'((scan_r + IW'(1)) >> 5);
    end else if (state_r == S_SCAN && rd_ok_r && scan_r[4:0] == 5'd31) begin
      raddr = AW'((scan_r + IW'(1)) >> 5);
    end
  end

  assign req_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_RESP);
  assign rsp.result_address = res_addr_r;
  assign rsp.success = res_ok_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(WORDS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            free_r <= req.req_type;
            cnt_r <= req.page_count;
            run_r <= '0;
            scan_r <= '0;
            limit_r <= act;
            rd_ok_r <= 1'b0;
            left_r <= {1'b0, req.page_count};
            res_addr_r <= '0;
            res_ok_r <= 1'b1;
            if (req.req_type == REQ_FREE) begin
              pos_r <= first_idx;
              // stop at index wrap: limit to pages below 2^20
              if (21'(first_idx) + 21'(req.page_count) > 21'h100000)
                left_r <= 14'(21'h100000 - 21'(first_idx));
              state_r <= (req.page_count == 0) ? S_RESP : S_MARK_RD;
            end else begin
              res_ok_r <= 1'b0;
              state_r <= (req.page_count == 0 || act == '0) ? S_RESP : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_ok_r <= 1'b1;
          if (rd_ok_r) begin
            if (scan_r[4:0] == 5'd31) rd_ok_r <= 1'b0;
            scan_r <= scan_r + IW'(1);
            if (cur_bit) begin
              run_r <= '0;
            end else if (run_r + 13'd1 == cnt_r) begin
              pos_r <= 20'(scan_r + IW'(1) - IW'(cnt_r));
              res_addr_r <= base_r +
                  (32'(scan_r + IW'(1) - IW'(cnt_r)) << PAGE_SHIFT);
              res_ok_r <= 1'b1;
              state_r <= S_MARK_RD;
            end else begin
              run_r <= run_r + 13'd1;
            end
            if (!(!cur_bit && run_r + 13'd1 == cnt_r) && scan_r + IW'(1) == limit_r)
              state_r <= S_RESP;
          end
        end
        S_MARK_RD: begin
          state_r <= S_MARK_WR;
        end
        S_MARK_WR: begin
          pos_r <= pos_r + 20'(nbits);
          left_r <= left_r - 14'(nbits);
          if (left_r == 14'(nbits) || !pos_in) state_r <= S_RESP;
          else state_r <= S_MARK_RD;
        end
        S_RESP: begin
          if (rsp_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_write_idle, clk, rst_n, state_r == S_IDLE, !we)
  `ASSERT_NEXT(a_resp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `ASSERT_IMPL(a_fail_zero, clk, rst_n, rsp_valid && !rsp.success, rsp.result_address == '0)
endmodule

FILE: src/bitmap_page_run_allocator_unit.sv
// Bitmap first-fit page run allocator. After reset the bitmap memory is
// cleared one word per cycle before requests are taken. An allocate scans
// one page bit per cycle, pausing to read each 32-bit word, from page 0
// up to the run end (at most the smaller of pool_pages and POOL_PAGES_MAX
// pages), then marks each touched word with a read step and a write step;
// a free clears each touched word in the same way. Each request is
// accepted in the idle state and its result is offered until it is taken.
// The bitmap memory has one registered read port. One result beat per
// request.
// depends on bpra_pkg, bpra_if, bpra_engine
module bitmap_page_run_allocator_unit import bpra_pkg::*; #(
  parameter int POOL_PAGES_MAX = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  bpra_req_if.sink    in_ch,
  bpra_rsp_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [31:0] base_r;
  logic [12:0] pages_r;
  req_t req;
  rsp_t rsp;

  assign cfg_pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      pages_r <= PAGES_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == REG_BASE) base_r <= cfg_pwdata;
      else pages_r <= cfg_pwdata[12:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_PAGES) cfg_prdata = {19'd0, pages_r};
    else cfg_prdata = base_r;
  end

  assign req.req_type = in_ch.req_type;
  assign req.page_count = in_ch.page_count;
  assign req.page_address = in_ch.page_address;
  assign out_ch.result_address = rsp.result_address;
  assign out_ch.success = rsp.success;

  bpra_engine #(.POOL_PAGES_MAX(POOL_PAGES_MAX)) u_engine (
    .clk, .rst_n,
    .req_valid(in_ch.valid), .req_ready(in_ch.ready), .req,
    .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready), .rsp,
    .base_r, .pages_r
  );
endmodule

FILE: sim/tb_bitmap_page_run_allocator_unit.sv
// testbench for the bitmap page run allocator: directed and random alloc/free beats
// checked against a bitmap predictor in a small scoreboard class
// depends on bpra_pkg, bpra_if and bitmap_page_run_allocator_unit
module tb_bitmap_page_run_allocator_unit import bpra_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES_MAX = 4096;

  // one run handed out by the allocator, kept so it can be given back
  typedef struct {
    logic [31:0] addr;
    logic [12:0] cnt;
  } page_run_t;

  // bitmap predictor and store of expected result beats
  class alloc_scoreboard;
    bit [PAGES_MAX-1:0] used_pages;
    logic [31:0]        pool_base;
    logic [12:0]        pool_pages;
    rsp_t               expected_rsp[$];
    page_run_t          live_runs[$];
    int                 errors;
    int                 n_alloc_ok;
    int                 n_alloc_fail;
    int                 n_free;

    function void reset_state();
      used_pages = '0;
      pool_base = BASE_RESET;
      pool_pages = PAGES_RESET;
      expected_rsp.delete();
      live_runs.delete();
    endfunction

    function void write_reg(logic [0:0] idx, logic [31:0] val);
      if (idx == REG_BASE) pool_base = val;
      else pool_pages = val[12:0];
    endfunction

    // predict the result of one accepted request and update the bitmap
    function void note_request(req_t rq);
      int unsigned limit;
      int unsigned run_len;
      int unsigned start;
      logic [31:0] first;
      logic [31:0] idx;
      bit          found;
      rsp_t        rs;
      rs = '0;
      run_len = 0;
      start = 0;
      found = 0;
      if (rq.req_type == REQ_ALLOC) begin
        limit = (pool_pages > PAGES_MAX) ? PAGES_MAX : pool_pages;
        if (rq.page_count != 0) begin
          for (int unsigned i = 0; i < limit; i++) begin
            if (used_pages[i]) run_len = 0;
            else begin
              run_len++;
              if (run_len == rq.page_count) begin
                start = i + 1 - rq.page_count;
                found = 1;
                break;
              end
            end
          end
        end
        if (found) begin
          for (int unsigned i = 0; i < rq.page_count; i++) used_pages[start + i] = 1'b1;
          rs.result_address = pool_base + (32'(start) << PAGE_SHIFT);
          rs.success = 1'b1;
          live_runs.push_back('{rs.result_address, rq.page_count});
          n_alloc_ok++;
        end else n_alloc_fail++;
      end else begin
        first = (rq.page_address - pool_base) >> PAGE_SHIFT;
        for (int unsigned i = 0; i < rq.page_count; i++) begin
          idx = first + i;
          if (idx < first) break;
          if (idx < PAGES_MAX) used_pages[idx] = 1'b0;
        end
        rs.success = 1'b1;
        n_free++;
      end
      expected_rsp.push_back(rs);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    // compare one result beat with the oldest expectation
    task check_result(logic [31:0] addr, logic ok);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        report($sformatf("unexpected result beat addr=%h success=%b", addr, ok));
        return;
      end
      want = expected_rsp.pop_front();
      if (addr !== want.result_address)
        report($sformatf("result_address %h, expected %h", addr, want.result_address));
      if (ok !== want.success)
        report($sformatf("success %b, expected %b", ok, want.success));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bpra_req_if in_if ();
  bpra_rsp_if out_if ();

  bitmap_page_run_allocator_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  alloc_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int n_sent;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side: ready changes at the falling edge
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result beats are checked at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.result_address, out_if.success);
  end

  // register write over the config port
  task cfg_write(logic [0:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = 3'(idx) << 2;
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // offer one request beat, with random idle cycles ahead of it
  task send_req(logic rt, logic [12:0] cnt, logic [31:0] addr);
    req_t rq;
    rq = '{rt, cnt, addr};
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.req_type = rt;
    in_if.page_count = cnt;
    in_if.page_address = addr;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(rq);
    n_sent++;
  endtask

  task drop_valid();
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // wait until every expected beat is in, then a little longer
  task drain();
    drop_valid();
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one random request: mostly allocs of small runs and frees of live runs
  task send_random(int unsigned pages);
    int unsigned r;
    int unsigned k;
    page_run_t   pr;
    r = $urandom_range(99);
    if (r < 50) begin
      if ($urandom_range(19) == 0) send_req(REQ_ALLOC, 13'($urandom_range(0, pages + 2)), $urandom);
      else send_req(REQ_ALLOC, 13'($urandom_range(1, 8)), $urandom);
    end else if (r < 88 && sb.live_runs.size() != 0) begin
      k = $urandom_range(sb.live_runs.size() - 1);
      pr = sb.live_runs[k];
      sb.live_runs.delete(k);
      send_req(REQ_FREE, pr.cnt, pr.addr);
    end else if (r < 94) begin
      // free near the pool with odd offsets and counts
      send_req(REQ_FREE, 13'($urandom_range(0, 40)),
               sb.pool_base + ($urandom_range(0, pages + 64) << PAGE_SHIFT) + $urandom_range(0, 4095));
    end else begin
      send_req(REQ_FREE, 13'($urandom), $urandom);
    end
  endtask

  task random_phase(int n, int unsigned pages);
    for (int i = 0; i < n; i++) send_random(pages);
    drain();
  endtask

  // stimulus
  initial begin
    sb = new();
    sb.reset_state();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    n_sent = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_ALLOC;
    in_if.page_count = '0;
    in_if.page_address = '0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at reset settings
    send_req(REQ_ALLOC, 13'd1, 32'h0);
    send_req(REQ_ALLOC, 13'd0, 32'hFFFF_FFFF);
    send_req(REQ_ALLOC, 13'd4096, 32'h0);
    send_req(REQ_FREE, 13'd0, BASE_RESET);
    send_req(REQ_FREE, 13'd1, BASE_RESET + 32'h0000_0ABC);
    send_req(REQ_FREE, 13'd3, BASE_RESET - 32'h0000_1000);
    send_req(REQ_ALLOC, 13'd4096, 32'h0);
    send_req(REQ_ALLOC, 13'd1, 32'h0);
    send_req(REQ_FREE, 13'd4096, BASE_RESET + (32'd4095 << PAGE_SHIFT));
    send_req(REQ_ALLOC, 13'd1, 32'h0);
    send_req(REQ_FREE, 13'd8191, BASE_RESET);
    send_req(REQ_ALLOC, 13'd8191, 32'h0);
    send_req(REQ_FREE, 13'd1, 32'hFFFF_FFFF);
    send_req(REQ_ALLOC, 13'd31, 32'h0);
    send_req(REQ_ALLOC, 13'd33, 32'h0);
    send_req(REQ_ALLOC, 13'd64, 32'h0);
    send_req(REQ_FREE, 13'd10, BASE_RESET + (32'd20 << PAGE_SHIFT));
    send_req(REQ_ALLOC, 13'd11, 32'h0);
    send_req(REQ_ALLOC, 13'd10, 32'h0);
    send_req(REQ_FREE, 13'd4096, BASE_RESET);
    drain();

    // top base so allocated addresses wrap, small pool, no idling
    cfg_write(REG_BASE, 32'hFFFF_F000);
    cfg_write(REG_PAGES, 32'd64);
    random_phase(350, 64);

    // empty pool: every alloc fails
    cfg_write(REG_BASE, 32'h0);
    cfg_write(REG_PAGES, 32'd0);
    random_phase(20, 0);

    // oversized pool setting, sender idling
    send_idle_pct = 85;
    cfg_write(REG_BASE, 32'($urandom) & 32'hFFFF_F000);
    cfg_write(REG_PAGES, 32'd8191);
    send_req(REQ_FREE, 13'd4096, sb.pool_base);
    random_phase(200, 256);

    // receiver stalls, with one long hold-off while requests keep coming
    send_idle_pct = 0;
    recv_stall_pct = 85;
    sb.live_runs.delete();
    cfg_write(REG_BASE, 32'($urandom) & 32'hFFFF_F000);
    cfg_write(REG_PAGES, 32'd200);
    send_req(REQ_FREE, 13'd4096, sb.pool_base);
    hold_left = 3000;
    random_phase(400, 200);

    // both sides idle now and then
    send_idle_pct = 13;
    recv_stall_pct = 13;
    cfg_write(REG_PAGES, 32'd100);
    random_phase(400, 100);

    // no idling, mid-size pool
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_write(REG_BASE, 32'h8000_0000);
    cfg_write(REG_PAGES, 32'd300);
    random_phase(400, 300);

    $display("sent %0d requests: %0d allocs granted, %0d refused, %0d frees",
             n_sent, sb.n_alloc_ok, sb.n_alloc_fail, sb.n_free);
    $display("pool sizes 0 to 8191, base at zero and at the top of the address space");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end
endmodule

FILE: bitmap_page_run_allocator_unit.f
+incdir+src
src/bpra_pkg.sv
src/bpra_if.sv
src/bpra_bitmap_ram.sv
src/bpra_engine.sv
src/bitmap_page_run_allocator_unit.sv
sim/tb_bitmap_page_run_allocator_unit.sv
